FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/tbom_pkg.sv
// Types and constants for the tensor block owner map.
// No dependencies; imported by tensor_block_owner_map.
package tbom_pkg;

  localparam int MODES_MAX = 4;
  localparam int LEN_W     = 32;
  localparam int GRID_W    = 9;
  localparam int BLK_W     = 8;
  localparam int DIV_BITS  = 4;
  localparam int DIV_STG   = LEN_W / DIV_BITS;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_LEN_0  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_0 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END    = 4'd8;

  localparam logic [GRID_W-1:0] GRID_MAX = 9'd256;

  typedef struct packed {
    logic [31:0] coord_0;
    logic [31:0] coord_1;
    logic [31:0] coord_2;
    logic [31:0] coord_3;
  } coord_t;

  typedef struct packed {
    logic [31:0] owner_rank;
    logic [7:0]  block_0;
    logic [7:0]  block_1;
    logic [7:0]  block_2;
    logic [7:0]  block_3;
    logic        out_of_range;
  } owner_t;

  typedef struct packed {
    logic [MODES_MAX-1:0][LEN_W-1:0] c;
    logic [MODES_MAX-1:0][LEN_W-1:0] q;
    logic [MODES_MAX-1:0][BLK_W-1:0] rem;
    logic [MODES_MAX-1:0][BLK_W-1:0] blk;
    logic [MODES_MAX-1:0]            oor;
    logic [LEN_W-1:0]                rank;
  } pipe_t;

  function automatic logic [GRID_W-1:0] eff_grid(logic [GRID_W-1:0] g, logic used);
    logic [GRID_W-1:0] res;
    begin
      if (!used || g == '0) begin
        res = 9'd1;
      end else if (g > GRID_MAX) begin
        res = GRID_MAX;
      end else begin
        res = g;
      end
      return res;
    end
  endfunction

endpackage

FILE: hw/rtl/tensor_block_owner_map.sv
// Tensor block owner map: coordinates in, owning grid rank and block indices out.
// Depends on tbom_pkg and assert_macros.svh.
//
// Usage: coordinate items arrive on coord/coord_valid/coord_stall and owner
// results leave on owner/owner_valid/owner_stall; a transfer happens at an
// edge with valid high and stall low. Registers are written on cfg_we with
// cfg_index and cfg_data: 0..3 mode lengths, 4..7 grid sizes; other indexes
// are ignored. Write them only while no item is in flight.
// The pipeline has 20 register stages; one item per cycle is taken unless
// owner_stall holds a valid result. Stages: input compare, 8 stages of 4-bit
// restoring division L/P per mode, 8 stages of block binary search (one 8x32
// multiply each), 3 stages of rank accumulation (one multiply each).
// Reset clears all stage valid bits and sets every length and grid size to 1.
// When owner_stall holds a valid result, the whole pipeline freezes and
// coord_stall goes high in the same cycle; nothing is dropped or repeated.
module tensor_block_owner_map
  import tbom_pkg::*;
#(
  parameter int NUM_MODES = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 coord_valid,
  output logic                 coord_stall,
  input  coord_t               coord,
  output logic                 owner_valid,
  input  logic                 owner_stall,
  output owner_t               owner,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data
);
`include "assert_macros.svh"

  localparam int SRCH0 = 1 + DIV_STG;
  localparam int RANK0 = SRCH0 + BLK_W;
  localparam int NSTG  = RANK0 + 3;
  localparam int LAST  = NSTG - 1;

  logic [MODES_MAX-1:0][LEN_W-1:0]  mode_len;
  logic [MODES_MAX-1:0][GRID_W-1:0] grid_reg;
  logic [MODES_MAX-1:0][GRID_W-1:0] p;
  logic [MODES_MAX-1:0]             used;

  pipe_t              st      [NSTG];
  pipe_t              st_next [NSTG];
  logic  [NSTG-1:0]   v;
  logic               adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MODES_MAX; i++) begin
        mode_len[i] <= 32'd1;
        grid_reg[i] <= 9'd1;
      end
    end else if (cfg_we) begin
      if (cfg_index < REG_GRID_0) begin
        mode_len[cfg_index[1:0]] <= cfg_data;
      end else if (cfg_index < REG_END) begin
        grid_reg[cfg_index[1:0]] <= cfg_data[GRID_W-1:0];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MODES_MAX; i++) begin
      used[i] = (i < NUM_MODES);
      p[i]    = eff_grid(grid_reg[i], used[i]);
    end
  end

  assign adv         = !(v[LAST] && owner_stall);
  assign coord_stall = !adv;

  always_comb begin
    logic [8:0]  t;
    logic [7:0]  trial;
    logic [7:0]  mn;
    logic [39:0] start;
    logic [40:0] prod;
    int          bitn;
    int          dj;

    st_next[0]      = st[0];
    st_next[0].c[0] = coord.coord_0;
    st_next[0].c[1] = coord.coord_1;
    st_next[0].c[2] = coord.coord_2;
    st_next[0].c[3] = coord.coord_3;
    st_next[0].q    = '0;
    st_next[0].rem  = '0;
    st_next[0].blk  = '0;
    st_next[0].rank = '0;
    for (int i = 0; i < MODES_MAX; i++) begin
      st_next[0].oor[i] = used[i] && (st_next[0].c[i] >= mode_len[i]);
    end

    for (int k = 1; k < NSTG; k++) begin
      st_next[k] = st[k-1];
      if (k < SRCH0) begin
        dj = k - 1;
        for (int i = 0; i < MODES_MAX; i++) begin
          for (int b = 0; b < DIV_BITS; b++) begin
            t = {st_next[k].rem[i], mode_len[i][LEN_W-1-dj*DIV_BITS-b]};
            if (t >= p[i]) begin
              t = t - p[i];
              st_next[k].q[i] = {st_next[k].q[i][LEN_W-2:0], 1'b1};
            end else begin
              st_next[k].q[i] = {st_next[k].q[i][LEN_W-2:0], 1'b0};
            end
            st_next[k].rem[i] = t[BLK_W-1:0];
          end
        end
      end else if (k < RANK0) begin
        bitn = BLK_W - 1 - (k - SRCH0);
        for (int i = 0; i < MODES_MAX; i++) begin
          trial = st[k-1].blk[i] | (8'd1 << bitn);
          mn    = (trial < st[k-1].rem[i]) ? trial : st[k-1].rem[i];
          start = 40'(trial) * 40'(st[k-1].q[i]) + 40'(mn);
          if (!st[k-1].oor[i] && ({1'b0, trial} < p[i]) &&
              (start <= 40'(st[k-1].c[i]))) begin
            st_next[k].blk[i] = trial;
          end
        end
      end else begin
        prod = 41'(st[k-1].rank) * 41'(p[k-RANK0+1]);
        if (k == RANK0) begin
          prod = 41'(st[k-1].blk[0]) * 41'(p[1]);
        end
        st_next[k].rank = prod[LEN_W-1:0] + 32'(st[k-1].blk[k-RANK0+1]);
        if (k == LAST && (|st[k-1].oor)) begin
          st_next[k].rank = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NSTG-2:0], coord_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NSTG; k++) begin
        st[k] <= st_next[k];
      end
    end
  end

  assign owner_valid        = v[LAST];
  assign owner.owner_rank   = st[LAST].rank;
  assign owner.block_0      = st[LAST].blk[0];
  assign owner.block_1      = st[LAST].blk[1];
  assign owner.block_2      = st[LAST].blk[2];
  assign owner.block_3      = st[LAST].blk[3];
  assign owner.out_of_range = |st[LAST].oor;

  `ASSERT_IMPLY(a_oor_rank, clk, rst, owner_valid && owner.out_of_range, owner.owner_rank == '0)
  `ASSERT_IMPLY(a_blk0_grid, clk, rst, owner_valid, {1'b0, owner.block_0} < p[0])
  `ASSERT_IMPLY(a_blk3_grid, clk, rst, owner_valid, {1'b0, owner.block_3} < p[3])
  `ASSERT_NEXT(a_freeze, clk, rst, owner_valid && owner_stall, owner_valid && $stable(v))

endmodule
